[src/dmc_pkg.sv]
// Package for the depth-first maze carver.
// Holds the sequencer state type, action and direction codes and the trial-order table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dmc_pkg;

    localparam int COORD_W = 5;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_STEP  = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_DOWN  = 2'd2,
        DIR_LEFT  = 2'd3
    } t_dir;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_INIT,
        ST_TRY,
        ST_TEST,
        ST_WALL,
        ST_FIN,
        ST_ENTRY,
        ST_EXIT,
        ST_READ
    } t_state;

    // The first direction to try sits in bits 7:6, the last in bits 1:0.
    function automatic logic [7:0] perm_order(input logic [4:0] rank);
        logic [4:0] r;
        logic [7:0] ord;
        r = (rank >= 5'd24) ? (rank - 5'd24) : rank;
        case (r)
            5'd0:    ord = 8'b00_01_10_11;
            5'd1:    ord = 8'b00_01_11_10;
            5'd2:    ord = 8'b00_10_01_11;
            5'd3:    ord = 8'b00_10_11_01;
            5'd4:    ord = 8'b00_11_01_10;
            5'd5:    ord = 8'b00_11_10_01;
            5'd6:    ord = 8'b01_00_10_11;
            5'd7:    ord = 8'b01_00_11_10;
            5'd8:    ord = 8'b01_10_00_11;
            5'd9:    ord = 8'b01_10_11_00;
            5'd10:   ord = 8'b01_11_00_10;
            5'd11:   ord = 8'b01_11_10_00;
            5'd12:   ord = 8'b10_00_01_11;
            5'd13:   ord = 8'b10_00_11_01;
            5'd14:   ord = 8'b10_01_00_11;
            5'd15:   ord = 8'b10_01_11_00;
            5'd16:   ord = 8'b10_11_00_01;
            5'd17:   ord = 8'b10_11_01_00;
            5'd18:   ord = 8'b11_00_01_10;
            5'd19:   ord = 8'b11_00_10_01;
            5'd20:   ord = 8'b11_01_00_10;
            5'd21:   ord = 8'b11_01_10_00;
            5'd22:   ord = 8'b11_10_00_01;
            5'd23:   ord = 8'b11_10_01_00;
            default: ord = 8'b00_01_10_11;
        endcase
        return ord;
    endfunction

endpackage

`default_nettype wire

[src/dfs_maze_carver_core.sv]
// Depth-first maze carver: grid memory, cell stack memory and the sequencer that walks them.
// Depends on dmc_pkg.
// Start runs a clearing pass over the grid memory and then puts cell (1,1) on the stack;
// step answers at once when finished, else tries each direction in turn on the
// single-port grid memory, closes the step and, once the stack is empty, opens entrance and
// exit; read answers at once when out of range, else after reading the grid memory.
// One transaction is handled at a time; busy is high until the result strobe is issued.
// After reset the grid memory is cleared with busy high.
// The result strobe lasts one cycle and the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none

module dfs_maze_carver_core
    import dmc_pkg::*;
#(
    parameter int MAX_SIZE    = 31,
    parameter int STACK_DEPTH = 225
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [4:0]         i_cfg_wdata,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic [1:0]         i_action,
    input  wire logic [4:0]         i_perm_index,
    input  wire logic [4:0]         i_read_x,
    input  wire logic [4:0]         i_read_y,
    output logic                    o_valid,
    output logic                    o_passage,
    output logic [2:0]              o_carved,
    output logic                    o_done_res,
    output logic [7:0]              o_stack_level
);

    localparam int CELLS = MAX_SIZE * MAX_SIZE;
    localparam int GA_W  = $clog2(CELLS);
    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int SI_W  = $clog2(STACK_DEPTH);
    localparam int SE_W  = 2 * COORD_W;

    t_state               r_state, n_state;
    logic                 r_from_start, n_from_start;
    logic [7:0]           r_order, n_order;
    logic [1:0]           r_trial, n_trial;
    logic [2:0]           r_carved, n_carved;
    logic [SP_W-1:0]      r_sp, n_sp;
    logic                 r_finished, n_finished;
    logic [4:0]           r_grid_size, n_grid_size;
    logic [GA_W-1:0]      r_clr, n_clr;
    logic [COORD_W-1:0]   r_nx, n_nx, r_ny, n_ny, r_wx, n_wx, r_wy, n_wy;
    logic                 r_out_valid, n_out_valid;
    logic                 r_passage, n_passage;
    logic [2:0]           r_out_carved, n_out_carved;
    logic                 r_done, n_done;
    logic [7:0]           r_level, n_level;

    logic                 r_grid_mem [CELLS];
    logic                 r_grid_q;
    logic                 grid_we, grid_wd;
    logic [GA_W-1:0]      grid_addr;

    logic [SE_W-1:0]      r_stk_mem [STACK_DEPTH];
    logic [SE_W-1:0]      r_stk_q;
    logic                 stk_we, stk_re;
    logic [SI_W-1:0]      stk_addr;
    logic [SE_W-1:0]      stk_wd;

    logic [5:0]           size6, sizem1;
    logic [SP_W-1:0]      sp_dec;
    logic                 stk_full;
    logic [5:0]           cx6, cy6, nx6, ny6, wx6, wy6;
    logic                 lo_ok, nb_ok;
    logic                 adv, fin, fin_passage;

    function automatic logic [GA_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] y);
        return GA_W'(x) * GA_W'(MAX_SIZE) + GA_W'(y);
    endfunction

    always_comb begin
        if (r_grid_size < 5'd5) begin
            size6 = 6'd5;
        end else if ({1'b0, r_grid_size} > 6'(MAX_SIZE)) begin
            size6 = 6'(MAX_SIZE);
        end else begin
            size6 = {1'b0, r_grid_size};
        end
    end

    assign sizem1   = size6 - 6'd1;
    assign sp_dec   = r_sp - SP_W'(1);
    assign stk_full = (r_sp >= SP_W'(STACK_DEPTH));

    always_comb begin
        cx6   = {1'b0, r_stk_q[SE_W-1:COORD_W]};
        cy6   = {1'b0, r_stk_q[COORD_W-1:0]};
        nx6   = cx6;
        ny6   = cy6;
        lo_ok = 1'b1;
        case (t_dir'(r_order[7:6]))
            DIR_UP: begin
                lo_ok = (cy6 >= 6'd2);
                ny6   = cy6 - 6'd2;
            end
            DIR_RIGHT: begin
                nx6 = cx6 + 6'd2;
            end
            DIR_DOWN: begin
                ny6 = cy6 + 6'd2;
            end
            DIR_LEFT: begin
                lo_ok = (cx6 >= 6'd2);
                nx6   = cx6 - 6'd2;
            end
            default: begin
                lo_ok = 1'b0;
            end
        endcase
        wx6   = (cx6 + nx6) >> 1;
        wy6   = (cy6 + ny6) >> 1;
        nb_ok = lo_ok && (nx6 < sizem1) && (ny6 < sizem1);
    end

    always_comb begin
        n_state      = r_state;
        n_from_start = r_from_start;
        n_order      = r_order;
        n_trial      = r_trial;
        n_carved     = r_carved;
        n_sp         = r_sp;
        n_finished   = r_finished;
        n_clr        = r_clr;
        n_nx         = r_nx;
        n_ny         = r_ny;
        n_wx         = r_wx;
        n_wy         = r_wy;
        n_grid_size  = i_cfg_we ? i_cfg_wdata : r_grid_size;
        grid_we      = 1'b0;
        grid_wd      = 1'b0;
        grid_addr    = '0;
        stk_we       = 1'b0;
        stk_re       = 1'b0;
        stk_addr     = r_sp[SI_W-1:0];
        stk_wd       = '0;
        adv          = 1'b0;
        fin          = 1'b0;
        fin_passage  = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_order  = perm_order(i_perm_index);
                    n_trial  = 2'd0;
                    n_carved = 3'd0;
                    case (t_action'(i_action))
                        ACT_START: begin
                            n_clr        = '0;
                            n_from_start = 1'b1;
                            n_state      = ST_CLEAR;
                        end
                        ACT_STEP: begin
                            if (!r_finished && (r_sp != '0)) begin
                                stk_re   = 1'b1;
                                stk_addr = sp_dec[SI_W-1:0];
                                n_sp     = sp_dec;
                                n_state  = ST_TRY;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        ACT_READ: begin
                            if (({1'b0, i_read_x} < size6) && ({1'b0, i_read_y} < size6)) begin
                                grid_addr = cell_addr(i_read_x, i_read_y);
                                n_state   = ST_READ;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                grid_we   = 1'b1;
                grid_addr = r_clr;
                n_clr     = r_clr + GA_W'(1);
                if (r_clr == GA_W'(CELLS - 1)) begin
                    n_state = r_from_start ? ST_INIT : ST_IDLE;
                end
            end
            ST_INIT: begin
                grid_we    = 1'b1;
                grid_wd    = 1'b1;
                grid_addr  = cell_addr(COORD_W'(1), COORD_W'(1));
                stk_we     = 1'b1;
                stk_addr   = '0;
                stk_wd     = {COORD_W'(1), COORD_W'(1)};
                n_sp       = SP_W'(1);
                n_finished = 1'b0;
                fin        = 1'b1;
                n_state    = ST_IDLE;
            end
            ST_TRY: begin
                n_nx = nx6[COORD_W-1:0];
                n_ny = ny6[COORD_W-1:0];
                n_wx = wx6[COORD_W-1:0];
                n_wy = wy6[COORD_W-1:0];
                if (nb_ok && !stk_full) begin
                    grid_addr = cell_addr(nx6[COORD_W-1:0], ny6[COORD_W-1:0]);
                    n_state   = ST_TEST;
                end else begin
                    adv = 1'b1;
                end
            end
            ST_TEST: begin
                if (!r_grid_q) begin
                    grid_we   = 1'b1;
                    grid_wd   = 1'b1;
                    grid_addr = cell_addr(r_nx, r_ny);
                    stk_we    = 1'b1;
                    stk_addr  = r_sp[SI_W-1:0];
                    stk_wd    = {r_nx, r_ny};
                    n_sp      = r_sp + SP_W'(1);
                    n_carved  = r_carved + 3'd1;
                    n_state   = ST_WALL;
                end else begin
                    adv = 1'b1;
                end
            end
            ST_WALL: begin
                grid_we   = 1'b1;
                grid_wd   = 1'b1;
                grid_addr = cell_addr(r_wx, r_wy);
                adv       = 1'b1;
            end
            ST_FIN: begin
                if (r_sp == '0) begin
                    n_state = ST_ENTRY;
                end else begin
                    fin     = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_ENTRY: begin
                grid_we   = 1'b1;
                grid_wd   = 1'b1;
                grid_addr = cell_addr(COORD_W'(1), COORD_W'(0));
                n_state   = ST_EXIT;
            end
            ST_EXIT: begin
                grid_we    = 1'b1;
                grid_wd    = 1'b1;
                grid_addr  = cell_addr(COORD_W'(size6 - 6'd2), COORD_W'(sizem1));
                n_finished = 1'b1;
                fin        = 1'b1;
                n_state    = ST_IDLE;
            end
            ST_READ: begin
                fin         = 1'b1;
                fin_passage = r_grid_q;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (adv) begin
            if (r_trial == 2'd3) begin
                n_state = ST_FIN;
            end else begin
                n_trial = r_trial + 2'd1;
                n_order = {r_order[5:0], 2'b00};
                n_state = ST_TRY;
            end
        end

        n_out_valid  = fin;
        n_passage    = fin ? fin_passage : r_passage;
        n_out_carved = fin ? n_carved : r_out_carved;
        n_done       = fin ? n_finished : r_done;
        n_level      = fin ? 8'(n_sp) : r_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_from_start <= 1'b0;
            r_trial      <= 2'd0;
            r_sp         <= '0;
            r_finished   <= 1'b1;
            r_grid_size  <= 5'd31;
            r_clr        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_from_start <= n_from_start;
            r_trial      <= n_trial;
            r_sp         <= n_sp;
            r_finished   <= n_finished;
            r_grid_size  <= n_grid_size;
            r_clr        <= n_clr;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_order      <= n_order;
        r_carved     <= n_carved;
        r_nx         <= n_nx;
        r_ny         <= n_ny;
        r_wx         <= n_wx;
        r_wy         <= n_wy;
        r_passage    <= n_passage;
        r_out_carved <= n_out_carved;
        r_done       <= n_done;
        r_level      <= n_level;
    end

    always_ff @(posedge i_clk) begin
        if (grid_we) begin
            r_grid_mem[grid_addr] <= grid_wd;
        end
        r_grid_q <= r_grid_mem[grid_addr];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk_mem[stk_addr] <= stk_wd;
        end else if (stk_re) begin
            r_stk_q <= r_stk_mem[stk_addr];
        end
    end

    assign o_busy        = (r_state != ST_IDLE) || !i_rst_n;
    assign o_valid       = r_out_valid;
    assign o_passage     = r_passage;
    assign o_carved      = r_out_carved;
    assign o_done_res    = r_done;
    assign o_stack_level = r_level;

endmodule

`default_nettype wire

[src/dmc_checker.sv]
// Port-level checker for the depth-first maze carver, with its bind to the top level.
// Depends only on the ports of dfs_maze_carver_core.
`timescale 1ns / 1ps
`default_nettype none

module dmc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_start,
    input wire logic       o_busy,
    input wire logic       o_valid,
    input wire logic       o_passage,
    input wire logic [2:0] o_carved,
    input wire logic       o_done_res,
    input wire logic [7:0] o_stack_level
);

    // An accepted transaction either completes at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_valid || o_busy))
        else $error("accepted transaction neither completed nor held busy");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result strobe while busy");

    a_done_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_done_res) |-> (o_stack_level == 8'd0))
        else $error("finished maze with a non-empty stack");

    a_carve_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_carved != 3'd0)) |-> (!o_done_res && !o_passage && (o_carved <= 3'd4)))
        else $error("carving result inconsistent with finished flag or passage");

endmodule

bind dfs_maze_carver_core dmc_checker u_dmc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_start       (i_start),
    .o_busy        (o_busy),
    .o_valid       (o_valid),
    .o_passage     (o_passage),
    .o_carved      (o_carved),
    .o_done_res    (o_done_res),
    .o_stack_level (o_stack_level)
);

`default_nettype wire

[sim/dfs_maze_carver_core_test.sv]
// Self-checking testbench for dfs_maze_carver_core: start, step, read and unused commands
// under many side lengths, each result checked against a cycle-free mirror of the carver.
// Depends on dmc_pkg and dfs_maze_carver_core.
`timescale 1ns / 1ps

module dfs_maze_carver_core_test;
    import dmc_pkg::*;

    localparam int SIDE_MAX    = 31;
    localparam int STACK_CAP   = 225;
    localparam int CMD_TARGET  = 1900;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int IDLE_PCT    = 31;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] action;
        logic [4:0] perm;
        logic [4:0] rx;
        logic [4:0] ry;
    } t_maze_cmd;

    typedef struct packed {
        logic       passage;
        logic [2:0] carved;
        logic       done_res;
        logic [7:0] level;
    } t_maze_status;

    logic       i_clk;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_we      = 1'b0;
    logic [4:0] i_cfg_wdata   = '0;
    logic       i_start       = 1'b0;
    logic [1:0] i_action      = '0;
    logic [4:0] i_perm_index  = '0;
    logic [4:0] i_read_x      = '0;
    logic [4:0] i_read_y      = '0;
    logic       o_busy;
    logic       o_valid;
    logic       o_passage;
    logic [2:0] o_carved;
    logic       o_done_res;
    logic [7:0] o_stack_level;

    dfs_maze_carver_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_action     (i_action),
        .i_perm_index (i_perm_index),
        .i_read_x     (i_read_x),
        .i_read_y     (i_read_y),
        .o_valid      (o_valid),
        .o_passage    (o_passage),
        .o_carved     (o_carved),
        .o_done_res   (o_done_res),
        .o_stack_level(o_stack_level)
    );

    t_maze_cmd    maze_cmd_q[$];
    t_maze_status want_status_q[$];
    t_maze_cmd    held_cmd;

    logic       mz_grid [0:SIDE_MAX-1][0:SIDE_MAX-1];
    logic [4:0] mz_stk_x [0:STACK_CAP-1];
    logic [4:0] mz_stk_y [0:STACK_CAP-1];
    int         mz_sp       = 0;
    logic       mz_finished = 1'b1;
    logic [4:0] mz_size_reg = 5'd31;

    bit calm = 1'b0;
    int queued_count   = 0;
    int accepted_count = 0;
    int errors         = 0;
    int cycle_count    = 0;
    int n_starts       = 0;
    int n_steps        = 0;
    int n_reads        = 0;
    int n_mazes        = 0;
    int n_carved       = 0;
    int n_cfg_writes   = 0;
    int max_level      = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int active_side();
        if (mz_size_reg < 5'd5) return 5;
        if (int'(mz_size_reg) > SIDE_MAX) return SIDE_MAX;
        return int'(mz_size_reg);
    endfunction

    function automatic int dir_dx(t_dir d);
        case (d)
            DIR_RIGHT: return 1;
            DIR_LEFT:  return -1;
            default:   return 0;
        endcase
    endfunction

    function automatic int dir_dy(t_dir d);
        case (d)
            DIR_UP:   return -1;
            DIR_DOWN: return 1;
            default:  return 0;
        endcase
    endfunction

    function automatic t_maze_status mirror_maze_cmd(t_maze_cmd c);
        t_maze_status st;
        int side, rank, pick, remaining, cx, cy, nx, ny;
        int fact [4];
        t_dir pool [4];
        t_dir d;
        st = '0;
        side = active_side();
        case (c.action)
            ACT_START: begin
                for (int x = 0; x < SIDE_MAX; x++) begin
                    for (int y = 0; y < SIDE_MAX; y++) begin
                        mz_grid[x][y] = 1'b0;
                    end
                end
                mz_grid[1][1] = 1'b1;
                mz_stk_x[0] = 5'd1;
                mz_stk_y[0] = 5'd1;
                mz_sp = 1;
                mz_finished = 1'b0;
            end
            ACT_STEP: begin
                if (!mz_finished && mz_sp > 0 && mz_sp <= STACK_CAP) begin
                    mz_sp--;
                    cx = mz_stk_x[mz_sp];
                    cy = mz_stk_y[mz_sp];
                    pool = '{DIR_UP, DIR_RIGHT, DIR_DOWN, DIR_LEFT};
                    fact = '{6, 2, 1, 1};
                    rank = int'(c.perm) % 24;
                    remaining = 4;
                    for (int i = 0; i < 4; i++) begin
                        pick = rank / fact[i];
                        rank = rank % fact[i];
                        if (pick >= remaining) pick = remaining - 1;
                        d = pool[pick];
                        for (int j = pick; j < remaining - 1; j++) pool[j] = pool[j + 1];
                        remaining--;
                        nx = cx + 2 * dir_dx(d);
                        ny = cy + 2 * dir_dy(d);
                        if (nx < 0 || nx >= side - 1 || ny < 0 || ny >= side - 1) continue;
                        if (mz_grid[nx][ny]) continue;
                        if (mz_sp >= STACK_CAP) continue;
                        mz_grid[nx][ny] = 1'b1;
                        mz_grid[cx + dir_dx(d)][cy + dir_dy(d)] = 1'b1;
                        mz_stk_x[mz_sp] = 5'(nx);
                        mz_stk_y[mz_sp] = 5'(ny);
                        mz_sp++;
                        st.carved = st.carved + 3'd1;
                    end
                    if (mz_sp == 0) begin
                        mz_grid[1][0] = 1'b1;
                        mz_grid[side - 2][side - 1] = 1'b1;
                        mz_finished = 1'b1;
                    end
                end
            end
            ACT_READ: begin
                if (int'(c.rx) < side && int'(c.ry) < side) st.passage = mz_grid[c.rx][c.ry];
            end
            default: ;
        endcase
        st.done_res = mz_finished;
        st.level = 8'(mz_sp);
        return st;
    endfunction

    always @(posedge i_clk) begin
        t_maze_status st;
        logic was_finished;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                was_finished = mz_finished;
                st = mirror_maze_cmd(held_cmd);
                want_status_q = {want_status_q, st};
                accepted_count++;
                if (held_cmd.action == ACT_START) n_starts++;
                if (held_cmd.action == ACT_STEP) n_steps++;
                if (held_cmd.action == ACT_READ) n_reads++;
                if (!was_finished && mz_finished) n_mazes++;
                n_carved += st.carved;
                if (st.level > max_level) max_level = st.level;
            end
            if (!i_start || !o_busy) begin
                if (maze_cmd_q.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    held_cmd = maze_cmd_q.pop_front();
                    i_start      <= 1'b1;
                    i_action     <= held_cmd.action;
                    i_perm_index <= held_cmd.perm;
                    i_read_x     <= held_cmd.rx;
                    i_read_y     <= held_cmd.ry;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    task automatic compare_field(input string what, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_maze_status want;
        if (i_rst_n && o_valid) begin
            if (want_status_q.size() == 0) begin
                errors++;
                $display({"%0t: result with no transaction outstanding, expected none, actual ",
                          "passage %0d carved %0d done %0d level %0d"},
                         $time, o_passage, o_carved, o_done_res, o_stack_level);
            end else begin
                want = want_status_q.pop_front();
                compare_field("passage", want.passage, o_passage);
                compare_field("carved", want.carved, o_carved);
                compare_field("done_res", want.done_res, o_done_res);
                compare_field("stack_level", want.level, o_stack_level);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, want_status_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic add_cmd(input logic [1:0] action, input logic [4:0] perm,
                           input logic [4:0] rx, input logic [4:0] ry);
        t_maze_cmd c;
        c.action = action;
        c.perm = perm;
        c.rx = rx;
        c.ry = ry;
        maze_cmd_q = {maze_cmd_q, c};
        queued_count++;
    endtask

    task automatic settle();
        do @(posedge i_clk);
        while (accepted_count != queued_count || want_status_q.size() != 0 || o_busy !== 1'b0);
    endtask

    task automatic write_side(input logic [4:0] value);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mz_size_reg = value;
        n_cfg_writes++;
    endtask

    initial begin
        int phase, side, k, steps_left, roll;
        logic [4:0] size_value;
        logic [4:0] rx, ry;
        for (int x = 0; x < SIDE_MAX; x++) begin
            for (int y = 0; y < SIDE_MAX; y++) begin
                mz_grid[x][y] = 1'b0;
            end
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset side length, then at the smallest side length.
        add_cmd(ACT_STEP, 5'd0, 5'd0, 5'd0);
        add_cmd(ACT_READ, 5'd0, 5'd0, 5'd0);
        add_cmd(ACT_READ, 5'd0, 5'd31, 5'd31);
        add_cmd(ACT_UNUSED, 5'd31, 5'd31, 5'd31);
        add_cmd(ACT_START, 5'd31, 5'd31, 5'd31);
        add_cmd(ACT_READ, 5'd0, 5'd1, 5'd1);
        add_cmd(ACT_STEP, 5'd0, 5'd0, 5'd0);
        add_cmd(ACT_STEP, 5'd23, 5'd0, 5'd0);
        add_cmd(ACT_STEP, 5'd24, 5'd0, 5'd0);
        add_cmd(ACT_STEP, 5'd31, 5'd0, 5'd0);
        add_cmd(ACT_READ, 5'd0, 5'd30, 5'd30);
        add_cmd(ACT_READ, 5'd0, 5'd1, 5'd2);
        write_side(5'd5);
        add_cmd(ACT_START, 5'd0, 5'd0, 5'd0);
        for (int i = 0; i < 4; i++) add_cmd(ACT_STEP, 5'($urandom_range(0, 31)), 5'd0, 5'd0);
        add_cmd(ACT_STEP, 5'd7, 5'd0, 5'd0);
        add_cmd(ACT_READ, 5'd0, 5'd1, 5'd0);
        add_cmd(ACT_READ, 5'd0, 5'd3, 5'd4);
        add_cmd(ACT_READ, 5'd0, 5'd4, 5'd4);
        add_cmd(ACT_READ, 5'd0, 5'd5, 5'd5);

        phase = 0;
        while (queued_count < CMD_TARGET) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) size_value = 5'($urandom_range(0, 4));
            else if (roll < 55) size_value = 5'($urandom_range(5, 11));
            else if (roll < 70) size_value = 5'd31;
            else size_value = 5'($urandom_range(12, 30));
            write_side(size_value);
            calm = (phase >= 4 && phase < 8);
            side = active_side();

            if (phase == 0 || $urandom_range(0, 99) < 85)
                add_cmd(ACT_START, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                        5'($urandom_range(0, 31)));
            k = (side - 1) / 2;
            steps_left = k * k + $urandom_range(0, 3);
            if ($urandom_range(0, 99) < 15) steps_left = $urandom_range(1, steps_left);

            while (steps_left > 0) begin
                roll = $urandom_range(0, 99);
                if ($urandom_range(0, 9) == 0) begin
                    rx = 5'($urandom_range(0, 31));
                    ry = 5'($urandom_range(0, 31));
                end else begin
                    rx = 5'($urandom_range(0, side - 1));
                    ry = 5'($urandom_range(0, side - 1));
                end
                if (roll < 68) begin
                    add_cmd(ACT_STEP, 5'($urandom_range(0, 31)), rx, ry);
                    steps_left--;
                end else if (roll < 94) begin
                    add_cmd(ACT_READ, 5'($urandom_range(0, 31)), rx, ry);
                end else if (roll < 98) begin
                    add_cmd(ACT_UNUSED, 5'($urandom_range(0, 31)), rx, ry);
                end else begin
                    add_cmd(ACT_START, 5'($urandom_range(0, 31)), rx, ry);
                end
            end

            if (side <= 9) begin
                for (int x = 0; x <= side; x++) begin
                    for (int y = 0; y <= side; y++) add_cmd(ACT_READ, 5'd0, 5'(x), 5'(y));
                end
            end else begin
                for (int i = 0; i < 24; i++)
                    add_cmd(ACT_READ, 5'($urandom_range(0, 31)), 5'($urandom_range(0, side)),
                            5'($urandom_range(0, side)));
            end
            phase++;
        end

        settle();
        repeat (40) @(posedge i_clk);
        $display("Covered %0d start, %0d step and %0d read commands over %0d side-length writes.",
                 n_starts, n_steps, n_reads, n_cfg_writes);
        $display("Finished %0d mazes, carved %0d cells, deepest stack %0d.",
                 n_mazes, n_carved, max_level);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
src/dmc_pkg.sv
src/dfs_maze_carver_core.sv
src/dmc_checker.sv
sim/dfs_maze_carver_core_test.sv
